>>> design/mbtp_pkg.sv
// Shared types and constants of the monochrome bitmap threshold packer.
// Used by mbtp_front, mbtp_back and the top level; no dependencies.
package mbtp_pkg;

    // Default image limits in pixels
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Configuration register fields
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_DIM_W  = 9;
    localparam int GRAY_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_VERTICAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [GRAY_W-1:0]    RST_THRESHOLD = 8'd128;
    localparam logic [CFG_DIM_W-1:0] RST_DIM       = 9'd1;

    // Operation codes of the input stream
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [2:0] BYTE_MSB = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] kind;
        logic            pix;
    } t_cmd;

    typedef struct packed {
        logic                 written;
        logic                 scan_vertical;
        logic                 lsb_first;
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
    } t_cfg;

endpackage

>>> design/mbtp_front.sv
// Front end of the packer: configuration registers, input stream accept,
// thresholding of pixel transactions and the command queue. Uses mbtp_pkg.
module mbtp_front import mbtp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [GRAY_W-1:0]     i_pixel_value,
    output t_cfg                  o_cfg,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_pop
);

    logic [GRAY_W-1:0]    r_threshold;
    logic                 r_scan_vertical;
    logic                 r_lsb_first;
    logic [CFG_DIM_W-1:0] r_image_width;
    logic [CFG_DIM_W-1:0] r_image_height;

    t_cmd                 r_queue [QDEPTH];
    logic [QPTR_W-1:0]    r_head;
    logic [QPTR_W-1:0]    r_tail;
    logic [QPTR_W:0]      r_count;

    logic cfg_wr;
    logic accept;
    logic push;
    logic pop;
    t_cmd cmd_in;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= RST_THRESHOLD;
            r_scan_vertical <= 1'b0;
            r_lsb_first     <= 1'b0;
            r_image_width   <= RST_DIM;
            r_image_height  <= RST_DIM;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_THRESHOLD:     r_threshold     <= i_cfg_data[GRAY_W-1:0];
                CFG_SCAN_VERTICAL: r_scan_vertical <= i_cfg_data[0];
                CFG_LSB_FIRST:     r_lsb_first     <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.written       = cfg_wr;
    assign o_cfg.scan_vertical = r_scan_vertical;
    assign o_cfg.lsb_first     = r_lsb_first;
    assign o_cfg.image_width   = r_image_width;
    assign o_cfg.image_height  = r_image_height;

    // Classify: drop unused codes here, reduce pixels to one bit
    assign o_ready     = (r_count != (QPTR_W+1)'(QDEPTH));
    assign accept      = i_valid && o_ready;
    assign push        = accept && (i_operation != OP_NONE);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign cmd_in.kind = i_operation;
    assign cmd_in.pix  = (i_pixel_value >= r_threshold);

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_head];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_tail] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/mbtp_back.sv
// Back end of the packer: one-bit pixel memory, frame counters, position
// recovery divider, byte gather sequencer and output register. Uses mbtp_pkg.
module mbtp_back import mbtp_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_packed_byte,
    output logic       o_last_byte
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 8);
    localparam int CMP_W   = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam int PAD_W   = ((MAX_WIDTH + 7) / 8) * 8;
    localparam int PAD_H   = ((MAX_HEIGHT + 7) / 8) * 8;
    localparam int STORE   = PAD_W * PAD_H;
    localparam int ADDR_W  = $clog2(STORE);
    localparam int LC_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RC_W    = $clog2((PAD_W / 8) * PAD_H + 1);
    localparam int DC_W    = $clog2(LC_W + 1);
    localparam int PROD_W  = 2 * DIM_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_FIX   = 4'd2;
    localparam logic [3:0] S_LDW   = 4'd3;
    localparam logic [3:0] S_MA    = 4'd4;
    localparam logic [3:0] S_MB    = 4'd5;
    localparam logic [3:0] S_BIT   = 4'd6;
    localparam logic [3:0] S_FLUSH = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic r_mem [STORE];
    logic r_mem_q;

    logic [3:0]        r_state;
    logic [LC_W-1:0]   r_ld_cnt;
    logic [RC_W-1:0]   r_rd_cnt;
    logic [DIM_W-1:0]  r_ld_x;
    logic [ADDR_W-1:0] r_ld_base;
    logic [DIM_W-1:0]  r_rd_major;
    logic [DIM_W-1:0]  r_rd_minor;
    logic              r_ld_stale;
    logic              r_rd_stale;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_pix;

    logic [LC_W-1:0]   r_tot_px;
    logic [RC_W-1:0]   r_tot_bytes;

    logic [LC_W-1:0]   r_dvd;
    logic [DIM_W-1:0]  r_dvs;
    logic [DIM_W:0]    r_rem;
    logic [DC_W-1:0]   r_dcnt;
    logic              r_div_rd;

    logic [DIM_W-1:0]  r_cur_x;
    logic [DIM_W-1:0]  r_cur_y;
    logic [ADDR_W-1:0] r_addr;
    logic [LC_W-1:0]   r_raster;
    logic [2:0]        r_bit_idx;
    logic [7:0]        r_byte;
    logic              r_p_vld;
    logic              r_p_ok;
    logic [2:0]        r_p_idx;

    logic [CMP_W-1:0]  w_raw;
    logic [CMP_W-1:0]  h_raw;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  pw_sum;
    logic [DIM_W-1:0]  ph_sum;
    logic [DIM_W-1:0]  pw;
    logic [DIM_W-1:0]  ph;
    logic [DIM_W-1:0]  per_row;
    logic [DIM_W-1:0]  per_col;
    logic [DIM_W-1:0]  per_line;
    logic [PROD_W-1:0] px_prod;
    logic [PROD_W-1:0] byte_prod;
    logic [PROD_W-1:0] fix_prod;
    logic [PROD_W-1:0] ma_prod;
    logic [PROD_W-1:0] mb_prod;
    logic [DIM_W-1:0]  minor_x8;
    logic [DIM_W-1:0]  a_row;
    logic [DIM_W-1:0]  a_col;
    logic [DIM_W:0]    rem_t;
    logic              rem_ge;
    logic [DIM_W:0]    rem_n;
    logic              ld_ok;
    logic              rd_ok;
    logic              mem_we;
    logic              mem_wd;
    logic [ADDR_W-1:0] mem_wa;
    logic              in_range;
    logic [2:0]        p_pos;

    // Effective and padded image size
    always_comb begin
        w_raw = CMP_W'(i_cfg.image_width);
        h_raw = CMP_W'(i_cfg.image_height);
        if (w_raw == '0) begin
            w = DIM_W'(1);
        end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = w_raw[DIM_W-1:0];
        end
        if (h_raw == '0) begin
            h = DIM_W'(1);
        end else if (h_raw > CMP_W'(MAX_HEIGHT)) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = h_raw[DIM_W-1:0];
        end
    end

    assign pw_sum   = w + DIM_W'(7);
    assign ph_sum   = h + DIM_W'(7);
    assign pw       = {pw_sum[DIM_W-1:3], 3'b000};
    assign ph       = {ph_sum[DIM_W-1:3], 3'b000};
    assign per_row  = pw >> 3;
    assign per_col  = ph >> 3;
    assign per_line = i_cfg.scan_vertical ? per_col : per_row;

    assign px_prod   = PROD_W'(w) * PROD_W'(h);
    assign byte_prod = PROD_W'(per_row) * PROD_W'(ph);

    always_ff @(posedge i_clk) begin
        r_tot_px    <= px_prod[LC_W-1:0];
        r_tot_bytes <= byte_prod[RC_W-1:0];
    end

    // One restoring divide step per cycle
    assign rem_t  = {r_rem[DIM_W-1:0], r_dvd[LC_W-1]};
    assign rem_ge = (rem_t >= {1'b0, r_dvs});
    assign rem_n  = rem_ge ? (rem_t - {1'b0, r_dvs}) : rem_t;

    assign fix_prod = PROD_W'(r_dvd[DIM_W-1:0]) * PROD_W'(pw);

    // Byte origin: line start in the scan direction
    assign minor_x8 = r_rd_minor << 3;
    assign a_row    = i_cfg.scan_vertical ? minor_x8 : r_rd_major;
    assign a_col    = i_cfg.scan_vertical ? r_rd_major : minor_x8;
    assign ma_prod  = PROD_W'(a_row) * PROD_W'(pw);
    assign mb_prod  = PROD_W'(r_cur_y) * PROD_W'(w);

    assign ld_ok = (r_ld_cnt < r_tot_px);
    assign rd_ok = (LC_W'(r_rd_cnt) < LC_W'(r_tot_bytes));

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        mem_we = 1'b0;
        mem_wd = r_pix;
        if (r_state == S_LDW) begin
            mem_we = 1'b1;
        end else if (o_cmd_pop && (i_cmd.kind == OP_LOAD) && ld_ok && !r_ld_stale) begin
            mem_we = 1'b1;
            mem_wd = i_cmd.pix;
        end
    end

    assign mem_wa   = r_ld_base + ADDR_W'(r_ld_x);
    assign in_range = (r_cur_x < w) && (r_cur_y < h) && (r_raster < r_ld_cnt);
    assign p_pos    = i_cfg.lsb_first ? r_p_idx : (BYTE_MSB - r_p_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ld_cnt    <= '0;
            r_rd_cnt    <= '0;
            r_ld_x      <= '0;
            r_ld_base   <= '0;
            r_rd_major  <= '0;
            r_rd_minor  <= '0;
            r_ld_stale  <= 1'b0;
            r_rd_stale  <= 1'b0;
            r_out_valid <= 1'b0;
            r_p_vld     <= 1'b0;
        end else begin
            r_p_vld <= 1'b0;
            if (r_p_vld) begin
                r_byte[p_pos] <= r_p_ok & r_mem_q;
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.written) begin
                r_ld_stale <= 1'b1;
                r_rd_stale <= 1'b1;
            end
            // Advance the raster write position after every stored pixel
            if (mem_we) begin
                r_ld_cnt <= r_ld_cnt + 1'b1;
                if (DIM_W'(r_ld_x + 1'b1) == w) begin
                    r_ld_x    <= '0;
                    r_ld_base <= r_ld_base + ADDR_W'(pw);
                end else begin
                    r_ld_x <= r_ld_x + 1'b1;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.kind)
                            OP_START: begin
                                r_ld_cnt   <= '0;
                                r_rd_cnt   <= '0;
                                r_ld_x     <= '0;
                                r_ld_base  <= '0;
                                r_rd_major <= '0;
                                r_rd_minor <= '0;
                                r_ld_stale <= 1'b0;
                                r_rd_stale <= 1'b0;
                            end
                            OP_LOAD: begin
                                if (ld_ok && r_ld_stale) begin
                                    r_dvd    <= r_ld_cnt;
                                    r_dvs    <= w;
                                    r_rem    <= '0;
                                    r_dcnt   <= '0;
                                    r_div_rd <= 1'b0;
                                    r_pix    <= i_cmd.pix;
                                    r_state  <= S_DIV;
                                end
                            end
                            OP_READ: begin
                                if (rd_ok) begin
                                    if (r_rd_stale) begin
                                        r_dvd    <= LC_W'(r_rd_cnt);
                                        r_dvs    <= per_line;
                                        r_rem    <= '0;
                                        r_dcnt   <= '0;
                                        r_div_rd <= 1'b1;
                                        r_state  <= S_DIV;
                                    end else begin
                                        r_state <= S_MA;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_dvd  <= {r_dvd[LC_W-2:0], rem_ge};
                    r_rem  <= rem_n;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DC_W'(LC_W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // Quotient is the line, remainder the place within it
                    if (r_div_rd) begin
                        r_rd_major <= r_dvd[DIM_W-1:0];
                        r_rd_minor <= r_rem[DIM_W-1:0];
                        r_rd_stale <= 1'b0;
                        r_state    <= S_MA;
                    end else begin
                        r_ld_x     <= r_rem[DIM_W-1:0];
                        r_ld_base  <= fix_prod[ADDR_W-1:0];
                        r_ld_stale <= 1'b0;
                        r_state    <= S_LDW;
                    end
                end
                S_LDW: begin
                    r_state <= S_IDLE;
                end
                S_MA: begin
                    r_cur_x <= i_cfg.scan_vertical ? r_rd_major : minor_x8;
                    r_cur_y <= i_cfg.scan_vertical ? minor_x8 : r_rd_major;
                    r_addr  <= ma_prod[ADDR_W-1:0] + ADDR_W'(a_col);
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_raster  <= mb_prod[LC_W-1:0] + LC_W'(r_cur_x);
                    r_byte    <= '0;
                    r_bit_idx <= '0;
                    r_state   <= S_BIT;
                end
                S_BIT: begin
                    r_p_vld <= 1'b1;
                    r_p_ok  <= in_range;
                    r_p_idx <= r_bit_idx;
                    if (i_cfg.scan_vertical) begin
                        r_cur_y  <= r_cur_y + 1'b1;
                        r_addr   <= r_addr + ADDR_W'(pw);
                        r_raster <= r_raster + LC_W'(w);
                    end else begin
                        r_cur_x  <= r_cur_x + 1'b1;
                        r_addr   <= r_addr + 1'b1;
                        r_raster <= r_raster + 1'b1;
                    end
                    r_bit_idx <= r_bit_idx + 1'b1;
                    if (r_bit_idx == BYTE_MSB) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_byte;
                        r_out_last  <= (RC_W'(r_rd_cnt + 1'b1) == r_tot_bytes);
                        r_rd_cnt    <= r_rd_cnt + 1'b1;
                        if (DIM_W'(r_rd_minor + 1'b1) == per_line) begin
                            r_rd_minor <= '0;
                            r_rd_major <= r_rd_major + 1'b1;
                        end else begin
                            r_rd_minor <= r_rd_minor + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_last_byte   = r_out_last;

endmodule

>>> design/mono_bitmap_threshold_packer_top.sv
// Top level of the monochrome bitmap threshold packer.
// Instantiates mbtp_front and mbtp_back; uses mbtp_pkg.

// A start transaction begins a frame, load transactions store one thresholded
// pixel each in raster order, and read transactions return the padded bitmap
// one packed byte at a time, row-wise or in eight-row column strips. A read is
// taken from the command queue, finds its byte origin with two multiplies,
// then makes eight reads of the one-bit pixel memory (one bit per cycle on its
// single read port), waits out the read latency and registers the byte; a byte
// still waiting on the output holds the next read in its register step. After a
// configuration write, the first load and the first read that come before the
// next start each pass first through the restoring divider, which recovers the
// pixel position from the running count one quotient bit for each of the LC_W
// bits of the load counter (17 at the default image limits), and such a load
// then writes its pixel in a step of its own. A four-entry command queue lets
// the front end keep accepting transactions while a read is in progress or its
// byte waits on the output.
module mono_bitmap_threshold_packer_top import mbtp_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,   // [1:0] operation, [9:2] pixel_value
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [7:0] packed_byte
    output logic                  o_m_tlast    // last_byte
);

    t_cfg cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    mbtp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_operation   (i_s_tdata[1:0]),
        .i_pixel_value (i_s_tdata[9:2]),
        .o_cfg         (cfg),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    mbtp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_packed_byte (o_m_tdata),
        .o_last_byte   (o_m_tlast)
    );

endmodule
